// ===== sv/piecewise_linear_interpolator_top_defines.svh =====
// ----------------------------------------------------------------------------
// piecewise linear interpolator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PLI_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pli check failed");

// implication after a fixed number of cycles
`define PLI_DELAY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("pli check failed");

`endif

// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// piecewise linear interpolator package
// defaults, operation codes and pipeline latency
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int POINTS_DEF    = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// edges from query acceptance to the edge that samples its done strobe
	localparam int PIPE_LAT = 42;

endpackage

// ===== sv/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli generic ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                      rdata_a,
	output logic [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/piecewise_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// piecewise linear interpolator
// breakpoint table with pipelined segment search, divide and multiply
// ----------------------------------------------------------------------------
// a word is accepted on an edge with start high and busy low; busy stays low,
// so a word may enter every cycle. operation selects load or query.
// a load writes one breakpoint and gives no result. a query gives one result
// on value and saturated, marked by done for a single cycle.
// throughput is one word per cycle. the slope comes from the 33 stage
// restoring divider, one quotient bit per stage, before multiply and scale.
// loads and queries keep their order: a query sees every load accepted before
// it and none after it. points_in_use is written through cfg_we and
// cfg_wdata only while idle: a rule for the user, not enforced by the block.
// reset clears the pipeline valid bits and sets points_in_use to one; the
// table holds no reset value and must be loaded before it is queried.
// the receiver cannot stall, so results leave at a fixed rate.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top import pli_pkg::*; #(
	parameter int POINTS    = POINTS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [3:0]         point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               done,
	output logic signed [31:0] value,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata
);

	localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;
	localparam int NW = 33 + FRAC_BITS;
	localparam int DW = 66;
	localparam int QB = 33;

	typedef struct packed {
		logic               v;
		logic               single;
		logic               dxz;
		logic               dyz;
		logic               dypos;
		logic               neg;
		logic               ovf;
		logic [DW-1:0]      r;
		logic [32:0]        d;
		logic [QB-1:0]      q;
		logic signed [32:0] dq;
		logic [31:0]        yres;
	} div_t;

	logic [4:0] pin_q;
	logic       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= 5'd1;
		end else if (cfg_we) begin
			pin_q <= cfg_wdata;
		end
	end

	// x copy in flops for the parallel compare
	logic signed [31:0] xr_q [POINTS];
	logic [IW+3:0]      in_idx_ext;
	logic               in_idx_ok;

	assign in_idx_ext = (IW + 4)'(point_index);
	assign in_idx_ok  = 32'(point_index) < POINTS;

	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD && in_idx_ok) begin
			xr_q[in_idx_ext[IW-1:0]] <= coord_x;
		end
	end

	// stage 1: accepted word
	logic               v_s1;
	logic               op_s1;
	logic [3:0]         idx_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operation;
		idx_s1 <= point_index;
		x_s1   <= coord_x;
		y_s1   <= coord_y;
	end

	// segment search
	logic [CW-1:0]     n_eff;
	logic [POINTS-1:0] gt;
	logic [POINTS-1:0] low;
	logic [IW-1:0]     h_enc;
	logic [IW-1:0]     h_sel;

	always_comb begin
		if (pin_q == 5'd0) begin
			n_eff = CW'(1);
		end else if (CW'(pin_q) > CW'(POINTS)) begin
			n_eff = CW'(POINTS);
		end else begin
			n_eff = CW'(pin_q);
		end
		for (int i = 0; i < POINTS; i++) begin
			gt[i] = (CW'(i) < n_eff) && (xr_q[i] > x_s1);
		end
		low   = gt & (~gt + POINTS'(1));
		h_enc = '0;
		for (int i = 0; i < POINTS; i++) begin
			if (low[i]) begin
				h_enc = h_enc | IW'(i);
			end
		end
		h_sel = (|gt) ? h_enc : IW'(n_eff - CW'(1));
		if (h_sel == '0) begin
			h_sel = IW'(1);
		end
	end

	// stage 2: table read and write
	logic               v_s2;
	logic               op_s2;
	logic [3:0]         idx_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] y_s2;
	logic [IW-1:0]      h_s2;
	logic               single_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		idx_s2    <= idx_s1;
		x_s2      <= x_s1;
		y_s2      <= y_s1;
		h_s2      <= h_sel;
		single_s2 <= n_eff == CW'(1);
	end

	logic [IW+3:0] idx2_ext;
	logic          ram_we;
	logic [IW-1:0] ra_lo;
	logic [31:0]   xa;
	logic [31:0]   xb;
	logic [31:0]   ya;
	logic [31:0]   yb;

	assign idx2_ext = (IW + 4)'(idx_s2);
	assign ram_we   = v_s2 && op_s2 == OP_LOAD && 32'(idx_s2) < POINTS;
	assign ra_lo    = h_s2 - IW'(1);

	pli_ram #(.WIDTH(32), .DEPTH(POINTS)) u_xram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (idx2_ext[IW-1:0]),
		.wdata   (x_s2),
		.raddr_a (ra_lo),
		.raddr_b (h_s2),
		.rdata_a (xa),
		.rdata_b (xb)
	);

	pli_ram #(.WIDTH(32), .DEPTH(POINTS)) u_yram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (idx2_ext[IW-1:0]),
		.wdata   (y_s2),
		.raddr_a (ra_lo),
		.raddr_b (h_s2),
		.rdata_a (ya),
		.rdata_b (yb)
	);

	// stage 3: read data arrives
	logic               v_s3;
	logic signed [31:0] q_s3;
	logic               single_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && op_s2 == OP_QUERY;
		end
	end

	always_ff @(posedge clk) begin
		q_s3      <= x_s2;
		single_s3 <= single_s2;
	end

	// stage 4: differences
	logic signed [32:0] dy_c;
	logic signed [32:0] dx_c;
	logic signed [32:0] dq_c;

	assign dy_c = 33'($signed(ya)) - 33'($signed(yb));
	assign dx_c = 33'($signed(xa)) - 33'($signed(xb));
	assign dq_c = 33'(q_s3) - 33'($signed(xb));

	logic               v_s4;
	logic               single_s4;
	logic [NW-1:0]      num_s4;
	logic [32:0]        den_s4;
	logic               neg_s4;
	logic               dxz_s4;
	logic               dyz_s4;
	logic               dypos_s4;
	logic signed [32:0] dq_s4;
	logic [31:0]        yres_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		single_s4 <= single_s3;
		num_s4    <= NW'(dy_c[32] ? -dy_c : dy_c) << FRAC_BITS;
		den_s4    <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
		neg_s4    <= dy_c[32] != dx_c[32];
		dxz_s4    <= dx_c == '0;
		dyz_s4    <= dy_c == '0;
		dypos_s4  <= !dy_c[32] && dy_c != '0;
		dq_s4     <= dq_c;
		yres_s4   <= single_s3 ? ya : yb;
	end

	// restoring divider, one quotient bit per stage
	div_t dv_q [QB+1];
	div_t dv0_c;

	always_comb begin
		dv0_c        = '0;
		dv0_c.v      = v_s4;
		dv0_c.single = single_s4;
		dv0_c.dxz    = dxz_s4;
		dv0_c.dyz    = dyz_s4;
		dv0_c.dypos  = dypos_s4;
		dv0_c.neg    = neg_s4;
		dv0_c.r      = DW'(num_s4);
		dv0_c.d      = den_s4;
		dv0_c.ovf    = DW'(num_s4) >= (DW'(den_s4) << QB);
		dv0_c.dq     = dq_s4;
		dv0_c.yres   = yres_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q[0].v <= 1'b0;
		end else begin
			dv_q[0] <= dv0_c;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		div_t          nxt;
		logic [DW-1:0] sh;

		always_comb begin
			nxt = dv_q[j];
			sh  = DW'(dv_q[j].d) << K;
			if (dv_q[j].r >= sh) begin
				nxt.r    = dv_q[j].r - sh;
				nxt.q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[j+1].v <= 1'b0;
			end else begin
				dv_q[j+1] <= nxt;
			end
		end
	end

	// slope clipping
	div_t        dvl;
	logic [31:0] lim;
	logic [31:0] smag_c;
	logic        sneg_c;
	logic        ssat_c;

	assign dvl = dv_q[QB];
	assign lim = dvl.neg ? 32'h8000_0000 : 32'h7fff_ffff;

	always_comb begin
		if (dvl.dxz) begin
			smag_c = dvl.dyz ? 32'd0 : (dvl.dypos ? 32'h7fff_ffff : 32'h8000_0000);
			sneg_c = !dvl.dypos && !dvl.dyz;
			ssat_c = !dvl.dyz;
		end else if (dvl.ovf || dvl.q > QB'(lim)) begin
			smag_c = lim;
			sneg_c = dvl.neg;
			ssat_c = 1'b1;
		end else begin
			smag_c = dvl.q[31:0];
			sneg_c = dvl.neg;
			ssat_c = 1'b0;
		end
	end

	logic        v_sc;
	logic        single_sc;
	logic [31:0] smag_sc;
	logic        sneg_sc;
	logic        ssat_sc;
	logic [32:0] dqm_sc;
	logic        dqneg_sc;
	logic [31:0] yres_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else begin
			v_sc <= dvl.v;
		end
	end

	always_ff @(posedge clk) begin
		single_sc <= dvl.single;
		smag_sc   <= smag_c;
		sneg_sc   <= sneg_c;
		ssat_sc   <= ssat_c;
		dqm_sc    <= dvl.dq[32] ? 33'(-dvl.dq) : 33'(dvl.dq);
		dqneg_sc  <= dvl.dq[32];
		yres_sc   <= dvl.yres;
	end

	// multiply
	logic        v_sm;
	logic        single_sm;
	logic [64:0] pm_sm;
	logic        pneg_sm;
	logic        ssat_sm;
	logic [31:0] yres_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else begin
			v_sm <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		single_sm <= single_sc;
		pm_sm     <= 65'(smag_sc) * 65'(dqm_sc);
		pneg_sm   <= sneg_sc != dqneg_sc;
		ssat_sm   <= ssat_sc;
		yres_sm   <= yres_sc;
	end

	// scale back with floor rounding
	logic [64:0] t_c;

	assign t_c = (pm_sm >> FRAC_BITS) +
		65'(pneg_sm && (pm_sm[FRAC_BITS-1:0] != '0));

	logic               v_sr;
	logic               single_sr;
	logic signed [65:0] term_sr;
	logic               ssat_sr;
	logic [31:0]        yres_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else begin
			v_sr <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		single_sr <= single_sm;
		term_sr   <= pneg_sm ? -$signed(66'(t_c)) : $signed(66'(t_c));
		ssat_sr   <= ssat_sm;
		yres_sr   <= yres_sm;
	end

	// add and clip
	logic signed [66:0] r_c;
	logic               hi_c;
	logic               lo_c;

	assign r_c  = 67'(term_sr) + 67'($signed(yres_sr));
	assign hi_c = r_c > 67'sd2147483647;
	assign lo_c = r_c < -67'sd2147483648;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (single_sr) begin
			value     <= $signed(yres_sr);
			saturated <= 1'b0;
		end else begin
			value     <= hi_c ? 32'sh7fff_ffff : (lo_c ? 32'sh8000_0000 : r_c[31:0]);
			saturated <= ssat_sr || hi_c || lo_c;
		end
	end

endmodule

// ===== sv/pli_checker.sv =====
// ----------------------------------------------------------------------------
// piecewise linear interpolator port checker
// result timing seen at the top level ports
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_top_defines.svh"

module pli_checker import pli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done
);

	logic acc_q;
	logic acc_l;

	assign acc_q = arst_n && start && !busy && operation == OP_QUERY;
	assign acc_l = arst_n && start && !busy && operation == OP_LOAD;

	`PLI_DELAY(a_query_gives_word, acc_q, PIPE_LAT, done)
	`PLI_DELAY(a_load_is_silent, acc_l, PIPE_LAT, !done)
	`PLI_IMPLIES(a_no_stray_word, done, $past(acc_q, PIPE_LAT))

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (.*);

// ===== dv/tb_piecewise_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// piecewise linear interpolator testbench
// loads breakpoint tables, queries them under several point counts and
// checks every result word against a cycle-free predictor of the block
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pli_pkg::*;

	localparam int NPTS  = 16;
	localparam int LIMIT = 200000;

	typedef struct {
		logic        op;
		logic [3:0]  idx;
		logic [31:0] x;
		logic [31:0] y;
	} word_t;

	typedef struct {
		logic signed [31:0] val;
		logic               sat;
	} interp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = OP_LOAD;
	logic [3:0] point_index = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic busy, done, saturated;
	logic signed [31:0] value;

	word_t   pending_words[$];
	interp_t expected_interp[$];
	longint  bp_x[NPTS];
	longint  bp_y[NPTS];
	longint  gen_x[NPTS];
	int      points_reg = 1;
	int      accepted = 0;
	int      errors = 0;
	int      cycles = 0;

	piecewise_linear_interpolator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .point_index(point_index),
		.coord_x(coord_x), .coord_y(coord_y), .done(done), .value(value),
		.saturated(saturated), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned mag64(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	function automatic interp_t interpolate(longint q);
		interp_t res;
		int n, h, i;
		bit found, neg;
		longint dy, dx, dq, slope, term, r;
		longint unsigned num, qm, pm, t;
		res.sat = 1'b0;
		n = points_reg;
		if (n < 1) n = 1;
		if (n > NPTS) n = NPTS;
		if (n == 1) begin
			res.val = bp_y[0][31:0];
			return res;
		end
		h = n;
		found = 0;
		for (i = 0; i < n; i++) begin
			if (!found && bp_x[i] > q) begin
				h = i;
				found = 1;
			end
		end
		if (h == n) h = n - 1;
		if (h == 0) h = 1;
		dy = bp_y[h-1] - bp_y[h];
		dx = bp_x[h-1] - bp_x[h];
		if (dx == 0) begin
			if (dy == 0) begin
				slope = 0;
			end else begin
				slope = (dy > 0) ? 64'sd2147483647 : -64'sd2147483648;
				res.sat = 1'b1;
			end
		end else begin
			num = mag64(dy) << FRAC_BITS_DEF;
			qm = num / mag64(dx);
			neg = (dy < 0) != (dx < 0);
			if (!neg) begin
				if (qm > 64'h7FFF_FFFF) begin
					qm = 64'h7FFF_FFFF;
					res.sat = 1'b1;
				end
				slope = qm;
			end else begin
				if (qm > 64'h8000_0000) begin
					qm = 64'h8000_0000;
					res.sat = 1'b1;
				end
				slope = -longint'(qm);
			end
		end
		dq = q - bp_x[h];
		pm = mag64(slope) * mag64(dq);
		neg = (slope < 0) != (dq < 0);
		t = pm >> FRAC_BITS_DEF;
		if (neg && (pm & ((64'd1 << FRAC_BITS_DEF) - 1)) != 0) t = t + 1;
		term = neg ? -longint'(t) : longint'(t);
		r = term + bp_y[h];
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			res.sat = 1'b1;
		end else if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			res.sat = 1'b1;
		end
		res.val = r[31:0];
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		word_t w;
		bit idle;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy) begin
				accepted <= accepted + 1;
				if (operation == OP_LOAD) begin
					bp_x[point_index] = longint'(coord_x);
					bp_y[point_index] = longint'(coord_y);
				end else begin
					expected_interp.push_back(interpolate(longint'(coord_x)));
				end
			end
			idle = (accepted >= 250 && accepted < 360) ? 1'b0 : ($urandom_range(0, 99) < 24);
			if (start && busy) begin
			end else if (pending_words.size() > 0 && !idle) begin
				w = pending_words.pop_front();
				start <= 1'b1;
				operation <= w.op;
				point_index <= w.idx;
				coord_x <= w.x;
				coord_y <= w.y;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		interp_t e;
		if (arst_n && done) begin
			if (expected_interp.size() == 0) begin
				$error("unexpected result word value=%0d saturated=%0b", value, saturated);
				errors <= errors + 1;
			end else begin
				e = expected_interp.pop_front();
				if (value !== e.val) begin
					$error("value expected %0d actual %0d", e.val, value);
					errors <= errors + 1;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, saturated);
					errors <= errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_word(logic op, logic [3:0] idx, logic [31:0] x, logic [31:0] y);
		word_t w;
		w.op = op;
		w.idx = idx;
		w.x = x;
		w.y = y;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || start || expected_interp.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 6) @(posedge clk);
	endtask

	task automatic write_points(logic [4:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		points_reg = v;
	endtask

	// ascending table, sometimes with a repeated x or scrambled order
	task automatic load_table();
		longint s, x0;
		int i, j, k;
		s = longint'(1) << $urandom_range(2, 27);
		x0 = -8 * s;
		for (i = 0; i < NPTS; i++)
			gen_x[i] = x0 + i * s + $urandom_range(0, int'(s - 1));
		if ($urandom_range(0, 9) < 2) begin
			j = $urandom_range(1, NPTS - 1);
			gen_x[j] = gen_x[j-1];
		end
		if ($urandom_range(0, 19) == 0) begin
			j = $urandom_range(0, NPTS - 1);
			gen_x[j] = longint'(int'($urandom));
		end
		for (i = 0; i < NPTS; i++) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(-40000, 40000) : int'($urandom);
			push_word(OP_LOAD, i, gen_x[i][31:0], k);
		end
	endtask

	task automatic random_words(int count);
		int i, j;
		longint q;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				j = $urandom_range(0, NPTS - 1);
				push_word(OP_LOAD, j, $urandom, $urandom);
			end else begin
				j = $urandom_range(0, NPTS - 1);
				case ($urandom_range(0, 3))
					0: q = longint'(int'($urandom));
					1: q = gen_x[j];
					default: q = gen_x[j] + longint'(int'($urandom_range(0, 200000))) - 100000;
				endcase
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				push_word(OP_QUERY, 0, q[31:0], $urandom);
			end
		end
	endtask

	initial begin
		int i, p;
		logic [4:0] settings[6];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-range table, single point, extremes
		for (i = 0; i < NPTS; i++)
			push_word(OP_LOAD, i, 32'h8000_0000 + i * 32'h1000_0000 + (i == NPTS-1 ? 32'h0FFF_FFFF : 0),
				(i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
		push_word(OP_QUERY, 0, 32'h8000_0000, 0);
		push_word(OP_QUERY, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		for (i = 0; i < NPTS; i++) gen_x[i] = longint'(int'(32'h8000_0000 + i * 32'h1000_0000));
		write_points(5'd16);
		push_word(OP_QUERY, 0, 32'h8000_0000, 0);
		push_word(OP_QUERY, 0, 32'h7FFF_FFFF, 0);
		push_word(OP_QUERY, 0, 32'h0000_0000, 0);
		push_word(OP_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF);
		push_word(OP_QUERY, 0, 32'h8000_0000, 0);
		push_word(OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000);
		push_word(OP_QUERY, 0, 32'hC000_0000, 0);
		push_word(OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000);
		push_word(OP_LOAD, 0, 32'h8000_0000, 32'h8000_0000);
		push_word(OP_QUERY, 0, 32'h8000_0000, 0);

		settings[0] = 5'd16;
		settings[1] = 5'd0;
		settings[2] = 5'd2;
		settings[3] = 5'd31;
		settings[4] = 5'd17;
		settings[5] = $urandom_range(3, 15);
		for (p = 0; p < 6; p++) begin
			write_points(settings[p]);
			load_table();
			random_words(50);
			load_table();
			random_words(20);
		end
		write_points(5'd1);
		random_words(10);
		drain();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
